// ===== rtl/pixel_neighbor_color_distance_defines.svh =====
// Assertion macros for the neighbor color distance block.
`ifndef PIXEL_NEIGHBOR_COLOR_DISTANCE_DEFINES_SVH
`define PIXEL_NEIGHBOR_COLOR_DISTANCE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PNCD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PNCD_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PNCD_ASSERT(label, clk, rst_n, prop, msg)
`define PNCD_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/pncd_pkg.sv =====
// ----------------------------------------------------------------------------
// pncd_pkg
// Types and constants shared by the neighbor color distance block.
// ----------------------------------------------------------------------------
package pncd_pkg;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CFG_W        = 12;
    localparam int PIX_W        = 24;
    localparam int DIST_W       = 16;
    localparam int SUM_W        = 30;
    localparam int SQRT_STEPS   = 16;
    localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 12'd640;
    localparam logic [28:0] DIST_DEN = 29'd298464750;

    // sequencer states of the control unit
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_OUT0,
        ST_CALC2,
        ST_OUT1
    } t_state;

    // job handed to the distance unit: centre and four neighbors
    typedef struct packed {
        logic [PIX_W-1:0] centre;
        logic [PIX_W-1:0] ul;
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] ur;
        logic [PIX_W-1:0] rt;
    } t_job;
endpackage

// ===== rtl/pncd_if.sv =====
// ----------------------------------------------------------------------------
// pncd_in_if / pncd_out_if
// Valid/ready channels carrying pixel words and distance result words.
// ----------------------------------------------------------------------------
interface pncd_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_rgb;
    logic        frame_start;
    modport source (output valid, pixel_rgb, frame_start, input ready);
    modport sink   (input valid, pixel_rgb, frame_start, output ready);
endinterface

interface pncd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] dist_top_left;
    logic [15:0] dist_top;
    logic [15:0] dist_top_right;
    logic [15:0] dist_right;
    logic        row_end;
    logic        run_last;
    modport source (output valid, dist_top_left, dist_top, dist_top_right, dist_right,
                    row_end, run_last, input ready);
    modport sink   (input valid, dist_top_left, dist_top, dist_top_right, dist_right,
                    row_end, run_last, output ready);
endinterface

// ===== rtl/pncd_dist.sv =====
// ----------------------------------------------------------------------------
// pncd_dist
// Four redmean distances, one after another: weighted sum in three registered
// steps, then a 16-step rounded square root against the scale, built from
// shifts and adds of running terms (no wide multiplier).
// ----------------------------------------------------------------------------
module pncd_dist
    import pncd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_job                  i_job,
    output logic                  o_done,
    output logic [DIST_W-1:0]     o_d0,
    output logic [DIST_W-1:0]     o_d1,
    output logic [DIST_W-1:0]     o_d2,
    output logic [DIST_W-1:0]     o_d3
);
    `include "pixel_neighbor_color_distance_defines.svh"

    typedef enum logic [2:0] {D_IDLE, D_SQ, D_MUL, D_ADD, D_ROOT} t_dstate;

    t_dstate r_st, n_st;
    t_job r_job;
    logic [1:0]  r_k;
    logic [4:0]  r_bit;
    logic [PIX_W-1:0] w_nb;
    logic [8:0]  r_sr, r_sg, r_sb;     // |dr|,|dg|,|db|
    logic [9:0]  r_rs;                 // r1+r2
    logic [15:0] r_qr, r_qg, r_qb;     // squares
    logic [26:0] r_pr, r_pb;
    logic [26:0] r_pg;
    logic [SUM_W-1:0] r_s;
    logic [15:0] r_q;
    logic [63:0] r_a;                  // 4*q^2*DEN
    logic [63:0] r_b;                  // 4*q*DEN
    logic [DIST_W-1:0] r_d [4];
    logic        r_done;
    logic [15:0] w_try;
    logic [63:0] w_den;
    logic [5:0]  w_sh1, w_sh2;
    logic [63:0] w_at, w_bt, w_lhs;
    logic        w_ok;

    always_comb begin
        case (r_k)
            2'd0:    w_nb = r_job.ul;
            2'd1:    w_nb = r_job.u;
            2'd2:    w_nb = r_job.ur;
            default: w_nb = r_job.rt;
        endcase
    end

    // test candidate t = q + 2^bit: (2t-1)^2*DEN <= S*2^32,
    // with 4t^2*DEN and 4t*DEN grown from the running terms
    assign w_try = r_q | (16'd1 << r_bit[3:0]);
    assign w_den = {35'd0, DIST_DEN};
    assign w_sh1 = {1'b0, r_bit} + 6'd1;
    assign w_sh2 = {r_bit, 1'b0} + 6'd2;
    assign w_at  = r_a + (r_b << w_sh1) + (w_den << w_sh2);
    assign w_bt  = r_b + (w_den << (w_sh1 + 6'd1));
    assign w_lhs = w_at - w_bt + w_den;
    assign w_ok  = (w_lhs <= {2'd0, r_s, 32'd0});

    always_comb begin
        n_st = r_st;
        case (r_st)
            D_IDLE:  if (i_start) n_st = D_SQ;
            D_SQ:    n_st = D_MUL;
            D_MUL:   n_st = D_ADD;
            D_ADD:   n_st = D_ROOT;
            D_ROOT:  if (r_bit == 5'd0) n_st = (r_k == 2'd3) ? D_IDLE : D_SQ;
            default: n_st = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= D_IDLE;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == D_ROOT) && (r_bit == 5'd0) && (r_k == 2'd3);
            if (r_st == D_IDLE && i_start) r_k <= 2'd0;
            else if (r_st == D_ROOT && r_bit == 5'd0) r_k <= r_k + 2'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_st == D_IDLE && i_start) r_job <= i_job;
        case (r_st)
            D_SQ: begin
                r_rs <= {2'd0, r_job.centre[23:16]} + {2'd0, w_nb[23:16]};
                r_sr <= (r_job.centre[23:16] >= w_nb[23:16]) ?
                        {1'b0, r_job.centre[23:16] - w_nb[23:16]} :
                        {1'b0, w_nb[23:16] - r_job.centre[23:16]};
                r_sg <= (r_job.centre[15:8] >= w_nb[15:8]) ?
                        {1'b0, r_job.centre[15:8] - w_nb[15:8]} :
                        {1'b0, w_nb[15:8] - r_job.centre[15:8]};
                r_sb <= (r_job.centre[7:0] >= w_nb[7:0]) ?
                        {1'b0, r_job.centre[7:0] - w_nb[7:0]} :
                        {1'b0, w_nb[7:0] - r_job.centre[7:0]};
            end
            D_MUL: begin
                r_qr <= r_sr[7:0] * r_sr[7:0];
                r_qg <= r_sg[7:0] * r_sg[7:0];
                r_qb <= r_sb[7:0] * r_sb[7:0];
            end
            D_ADD: begin
                r_pr  <= 27'(({11'd0, r_qr}) * (27'd1020 + {17'd0, r_rs}));
                r_pg  <= 27'({11'd0, r_qg} * 27'd2040);
                r_pb  <= 27'(({11'd0, r_qb}) * (27'd1530 - {17'd0, r_rs}));
                r_q   <= 16'd0;
                r_a   <= '0;
                r_b   <= '0;
                r_bit <= 5'd16;
            end
            D_ROOT: begin
                if (r_bit == 5'd16) begin
                    r_s   <= SUM_W'({3'd0, r_pr} + {3'd0, r_pg} + {3'd0, r_pb});
                    r_bit <= 5'd15;
                end else begin
                    // keep the candidate bit when it still fits
                    if (w_ok) begin
                        r_q <= w_try;
                        r_a <= w_at;
                        r_b <= w_bt;
                    end
                    if (r_bit == 5'd0) r_d[r_k] <= w_ok ? w_try : r_q;
                    else r_bit <= r_bit - 5'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_d0 = r_d[0];
    assign o_d1 = r_d[1];
    assign o_d2 = r_d[2];
    assign o_d3 = r_d[3];

    `PNCD_ASSERT(a_done_from_root, i_clk, i_rst_n, o_done |-> $past(r_st == D_ROOT), "done without root")
    `PNCD_ASSERT(a_no_restart, i_clk, i_rst_n, (r_st != D_IDLE) |=> !(r_st == D_SQ && $past(r_st) == D_IDLE && r_k != 2'd0), "restart while busy")
    `PNCD_ASSERT(a_bit_range, i_clk, i_rst_n, (r_st == D_ROOT) |-> (r_bit <= 5'd16), "bit index out of range")
endmodule

// ===== rtl/pixel_neighbor_color_distance.sv =====
// ----------------------------------------------------------------------------
// pixel_neighbor_color_distance
// Redmean color distance of each pixel to its upper-left, upper, upper-right
// and right neighbors, from a line store of the previous row.
// ----------------------------------------------------------------------------
// One pixel word is taken at a time. Each result costs one pass of the shared
// distance unit: four distances, each a weighted sum and then a square root.
// Column 0 of a row wider than one pixel gives no result, any other pixel gives
// one, and the last pixel of a row gives a second result; a width of one gives
// one result per pixel. A result word that waits on ready holds back the next
// pixel. Results lag by one pixel. The line store needs no clearing pass; the
// first row of a frame reads itself.
module pixel_neighbor_color_distance
    import pncd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    pncd_in_if.sink          i_in,
    pncd_out_if.source       o_out
);
    `include "pixel_neighbor_color_distance_defines.svh"

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [CFG_W-1:0] r_lw;
    logic [PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd;
    t_state r_st, n_st;
    logic [CW-1:0] r_col, w_cin, r_c;
    logic [CW-1:0] w_w;
    logic        r_first, r_fr_eff;
    logic [PIX_W-1:0] r_px, r_held, r_win0, r_win1, r_win2, w_up;
    logic        r_last;    // column is w-1
    logic        w_start, w_done;
    t_job        w_job;
    logic [DIST_W-1:0] w_d0, w_d1, w_d2, w_d3;
    logic        r_ov, r_re, r_rl;
    logic [DIST_W-1:0] r_o0, r_o1, r_o2, r_o3;

    // clamp width to 1..MAX_WIDTH
    always_comb begin
        if (r_lw == '0) w_w = CW'(1);
        else if ({20'd0, r_lw} > 32'(MAX_WIDTH)) w_w = CW'(MAX_WIDTH);
        else w_w = CW'(r_lw);
    end
    assign w_cin = (i_in.frame_start || r_col >= w_w) ? '0 : r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lw <= LINE_WIDTH_RST;
        else if (i_cfg_we) r_lw <= i_cfg_wdata;
    end

    // line store: read at accept, write the new pixel back in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_rd <= r_mem[w_cin[AW-1:0]];
            r_mem[w_cin[AW-1:0]] <= i_in.pixel_rgb;
        end
    end

    assign w_up = r_fr_eff ? r_px : r_rd;
    assign i_in.ready = (r_st == ST_IDLE);
    assign w_start = (r_st == ST_READ && r_c != '0) || (r_st == ST_OUT0 && !r_ov && r_last);

    // pick the job from the shifted window: held pixel first, then row end
    always_comb begin
        w_job.centre = r_held;
        w_job.ul = r_win1; w_job.u = r_win2; w_job.ur = w_up; w_job.rt = r_px;
        if (r_st == ST_OUT0) begin
            w_job.centre = r_px;
            w_job.ul = r_win1; w_job.u = r_win2; w_job.ur = r_win2;
        end
    end

    pncd_dist u_dist (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_job(w_job),
        .o_done(w_done), .o_d0(w_d0), .o_d1(w_d1), .o_d2(w_d2), .o_d3(w_d3)
    );

    // sequencer
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (i_in.valid) n_st = ST_READ;
            ST_READ:  n_st = (r_c != '0) ? ST_CALC : (r_last ? ST_OUT0 : ST_IDLE);
            ST_CALC:  if (w_done) n_st = ST_OUT0;
            ST_OUT0:  if (!r_ov) n_st = r_last ? ST_CALC2 : ST_IDLE;
            ST_CALC2: if (w_done) n_st = ST_OUT1;
            ST_OUT1:  if (!r_ov) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_col <= '0; r_first <= 1'b1; r_ov <= 1'b0;
            r_held <= '0; r_win0 <= '0; r_win1 <= '0; r_win2 <= '0;
        end else begin
            r_st <= n_st;
            if (o_out.valid && o_out.ready) r_ov <= 1'b0;
            if (i_in.valid && i_in.ready) begin
                r_px     <= i_in.pixel_rgb;
                r_c      <= w_cin;
                r_fr_eff <= i_in.frame_start | r_first;
                r_last   <= (w_cin == w_w - CW'(1));
                if (w_cin == w_w - CW'(1)) begin
                    r_col <= '0; r_first <= 1'b0;
                end else begin
                    r_col <= w_cin + CW'(1);
                    if (i_in.frame_start) r_first <= 1'b1;
                end
            end
            // shift the upper window
            if (r_st == ST_READ) begin
                r_win2 <= w_up;
                r_win1 <= (r_c == '0) ? w_up : r_win2;
                r_win0 <= (r_c == '0) ? w_up : r_win1;
            end
            if ((r_st == ST_CALC || r_st == ST_CALC2) && w_done) begin
                r_ov <= 1'b1; r_o0 <= w_d0; r_o1 <= w_d1; r_o2 <= w_d2; r_o3 <= w_d3;
                r_re <= (r_st == ST_CALC2); r_rl <= (r_st == ST_CALC2) || !r_last;
            end
            // hold the pixel whose result comes next
            if (r_st == ST_READ)
                r_held <= r_px;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.dist_top_left = r_o0;
    assign o_out.dist_top = r_o1;
    assign o_out.dist_top_right = r_o2;
    assign o_out.dist_right = r_o3;
    assign o_out.row_end = r_re;
    assign o_out.run_last = r_rl;

    `PNCD_ASSERT(a_ready_idle, i_clk, i_rst_n, i_in.ready |-> !r_ov || o_out.valid, "ready with lost word")
    `PNCD_ASSERT(a_idle_no_word, i_clk, i_rst_n, (r_st == ST_IDLE) |-> !o_out.valid, "word pending in idle")
    `PNCD_ASSERT_RST(a_rst_out, i_clk, !i_rst_n |=> !o_out.valid, "output valid after reset")
endmodule

// ===== sim/pixel_neighbor_color_distance_tb.sv =====
// ----------------------------------------------------------------------------
// pixel_neighbor_color_distance_tb
// Drives pixel words in raster order through the neighbor color distance
// block and checks every result word against a predictor kept in the bench.
// Directed frames cover color extremes, border clamping, tiny and oversized
// widths, frame restarts and width changes; random frames follow, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module pixel_neighbor_color_distance_tb;
    import pncd_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH_DEF;
    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE_CYC  = 200;
    localparam longint unsigned DIST_SCALE = 64'd298464750;

    typedef struct packed {
        logic [15:0] top_left;
        logic [15:0] top;
        logic [15:0] top_right;
        logic [15:0] right;
        logic        row_end;
        logic        run_last;
    } t_dist_word;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    pncd_in_if  in_ch ();
    pncd_out_if out_ch ();

    pixel_neighbor_color_distance u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // predictor state
    logic [23:0]      row_store [STORE_DEPTH];
    logic [23:0]      pend_pixel;
    logic [23:0]      up_win [3];
    int unsigned      col_pos;
    bit               on_first_row;
    logic [CFG_W-1:0] width_reg;

    t_dist_word dist_q [$];
    int  err_count;
    int  pixel_count;
    bit  idle_en;
    int  quiet_cycles;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // redmean distance, rounded to nearest in Q1.15
    function automatic logic [15:0] redmean_dist(logic [23:0] a, logic [23:0] b);
        longint r1, r2, g1, g2, b1, b2, dr, dg, db, s;
        longint unsigned t, odd;
        int unsigned lo, hi, mid;
        r1 = a[23:16]; r2 = b[23:16];
        g1 = a[15:8];  g2 = b[15:8];
        b1 = a[7:0];   b2 = b[7:0];
        dr = r1 - r2; dg = g1 - g2; db = b1 - b2;
        s = (1020 + r1 + r2) * dr * dr + 2040 * dg * dg + (1530 - r1 - r2) * db * db;
        t = longint'(s) << 32;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 2 * longint'(mid) - 1;
            if (odd * odd * DIST_SCALE <= t) lo = mid;
            else hi = mid - 1;
        end
        return lo[15:0];
    endfunction

    function automatic t_dist_word make_word(logic [23:0] ctr, logic [23:0] ul,
                                             logic [23:0] u, logic [23:0] ur,
                                             logic [23:0] rt, bit re, bit last);
        t_dist_word w;
        w.top_left  = redmean_dist(ctr, ul);
        w.top       = redmean_dist(ctr, u);
        w.top_right = redmean_dist(ctr, ur);
        w.right     = redmean_dist(ctr, rt);
        w.row_end   = re;
        w.run_last  = last;
        return w;
    endfunction

    // advance the predictor by one accepted pixel word
    function automatic void predict_pixel(logic [23:0] px, bit fs);
        int unsigned w, c;
        logic [23:0] up;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > STORE_DEPTH) w = STORE_DEPTH;
        if (fs) begin
            col_pos = 0;
            on_first_row = 1'b1;
        end
        if (col_pos >= w) col_pos = 0;
        c = col_pos;
        up = on_first_row ? px : row_store[c];
        row_store[c] = px;
        if (c == 0) begin
            up_win[0] = up; up_win[1] = up; up_win[2] = up;
        end else begin
            up_win[0] = up_win[1];
            up_win[1] = up_win[2];
            up_win[2] = up;
            dist_q.push_back(make_word(pend_pixel, up_win[0], up_win[1], up_win[2], px,
                                       1'b0, c != w - 1));
        end
        if (c == w - 1) begin
            dist_q.push_back(make_word(px, up_win[1], up_win[2], up_win[2], px,
                                       1'b1, 1'b1));
            col_pos = 0;
            on_first_row = 1'b0;
        end else begin
            col_pos = c + 1;
        end
        pend_pixel = px;
    endfunction

    // send one pixel word, with an optional random gap first
    task automatic send_pixel(logic [23:0] px, bit fs);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.pixel_rgb   = px;
        in_ch.frame_start = fs;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_pixel(px, fs);
        pixel_count++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain_results();
        while (dist_q.size() != 0) @(negedge i_clk);
    endtask

    // write line_width once the block has gone idle
    task automatic set_line_width(logic [CFG_W-1:0] v);
        drain_results();
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        width_reg = v;
    endtask

    function automatic logic [23:0] rand_pixel();
        logic [23:0] p;
        if ($urandom_range(0, 3) == 0) begin
            p[23:16] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p[15:8]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p[7:0]   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
            p = 24'($urandom());
        end
        return p;
    endfunction

    task automatic send_frame(int unsigned n);
        for (int unsigned i = 0; i < n; i++) send_pixel(rand_pixel(), i == 0);
    endtask

    // color extremes over four rows, so the upper row comes from the store
    task automatic test_color_extremes();
        logic [23:0] pal [6];
        pal = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00};
        set_line_width(12'd3);
        for (int i = 0; i < 6; i++) send_pixel(pal[i], i == 0);
        for (int i = 0; i < 6; i++) send_pixel(pal[5 - i], 1'b0);
    endtask

    // widths 0 and 1 give one result per pixel
    task automatic test_narrow_widths();
        set_line_width(12'd0);
        send_frame(3);
        set_line_width(12'd1);
        send_frame(3);
    endtask

    // restart a frame while a row is unfinished
    task automatic test_frame_restart();
        set_line_width(12'd4);
        send_frame(6);
        send_pixel(24'h123456, 1'b1);
        send_pixel(24'hABCDEF, 1'b0);
        send_pixel(24'h00FF80, 1'b0);
    endtask

    // shrink the width while the row position is past the new width
    task automatic test_width_shrink();
        set_line_width(12'd5);
        send_frame(9);
        set_line_width(12'd2);
        repeat (5) send_pixel(rand_pixel(), 1'b0);
    endtask

    // out-of-range width keeps the row open well past the short widths
    task automatic test_full_width();
        set_line_width(12'hFFF);
        send_frame(64);
    endtask

    // hold off the sender mid-frame until every result is back
    task automatic test_sender_holdoff();
        set_line_width(12'd6);
        send_frame(8);
        drain_results();
        repeat (10) send_pixel(rand_pixel(), 1'b0);
    endtask

    task automatic test_random_frames(int unsigned target);
        int unsigned start, w, n;
        logic [CFG_W-1:0] wv;
        start = pixel_count;
        while (pixel_count - start < target) begin
            if (pixel_count - start > target - 150) idle_en = 1'b0;
            case ($urandom_range(0, 9))
                0:       wv = 12'd0;
                1:       wv = CFG_W'($urandom_range(13, 40));
                default: wv = CFG_W'($urandom_range(1, 12));
            endcase
            set_line_width(wv);
            w = (wv == 0) ? 1 : wv;
            n = w * $urandom_range(1, 4) + $urandom_range(0, w);
            for (int unsigned i = 0; i < n; i++)
                send_pixel(rand_pixel(), i == 0 || $urandom_range(0, 49) == 0);
        end
    endtask

    // result ready with random stall bursts
    initial begin
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 15) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                out_ch.ready = 1'b1;
            end
        end
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_dist_word got, exp_w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.dist_top_left, out_ch.dist_top, out_ch.dist_top_right,
                    out_ch.dist_right, out_ch.row_end, out_ch.run_last};
            if (dist_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                err_count++;
            end else begin
                exp_w = dist_q.pop_front();
                if (got !== exp_w) begin
                    $display("%0t: mismatch expected tl=%0d t=%0d tr=%0d r=%0d re=%0b rl=%0b",
                             $time, exp_w.top_left, exp_w.top, exp_w.top_right,
                             exp_w.right, exp_w.row_end, exp_w.run_last);
                    $display("%0t:          actual   tl=%0d t=%0d tr=%0d r=%0d re=%0b rl=%0b",
                             $time, got.top_left, got.top, got.top_right,
                             got.right, got.row_end, got.run_last);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_ch.valid       = 1'b0;
        in_ch.pixel_rgb   = '0;
        in_ch.frame_start = 1'b0;
        err_count         = 0;
        pixel_count       = 0;
        quiet_cycles      = 0;
        idle_en           = 1'b1;
        width_reg         = LINE_WIDTH_RST;
        pend_pixel        = '0;
        up_win            = '{default: '0};
        col_pos           = 0;
        on_first_row      = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_color_extremes();
        test_narrow_widths();
        test_frame_restart();
        test_width_shrink();
        test_sender_holdoff();
        test_full_width();
        test_random_frames(850);

        drain_results();
        repeat (SETTLE_CYC) @(negedge i_clk);
        if (err_count == 0 && dist_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
